// File: src/srtf_tick_scheduler_top_assert.svh
// Assertion macros shared by the scheduler's checker.
`ifndef SRTF_TICK_SCHEDULER_TOP_ASSERT_SVH
`define SRTF_TICK_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRTF_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRTF_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define SRTF_ASSERT_NEXT_ALWAYS(name, ante, cons, msg) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/srtf_pkg.sv
// Shared types and constants of the shortest-remaining-time-first scheduler.
package srtf_pkg;

   // Task table size and derived widths.
   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);

   // Field widths.
   localparam int CMD_W  = 2;
   localparam int SLOT_W = 4;
   localparam int WORK_W = 16;
   localparam int TIME_W = 32;

   // Table entry: arrival, burst, remaining (remaining in the low bits).
   localparam int ENTRY_W = 3 * WORK_W;

   // Stream widths.
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = CMD_W;
   localparam int RSP_DATA_W = 136;
   localparam int RSP_USER_W = 1;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_DECIDE,
      ST_TURN,
      ST_WAIT,
      ST_PUSH
   } state_type;

endpackage

// File: src/srtf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
module srtf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: src/srtf_tick_scheduler_top.sv
// Top level of the shortest-remaining-time-first tick scheduler.
// Load and clear beats are handled in the idle state and return no result.
// A tick beat scans the task table one entry per cycle through the table RAM
// read port, then steps through the last, decide, turnaround, wait and push
// states; the next beat is taken once the result is in the output register.
// Reset clears every pending mark, zeroes time and drops the running mark at once.
module srtf_tick_scheduler_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // slot[3:0], arrival[19:4], burst[35:20], zero fill
   input  logic [srtf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command[1:0]
   input  logic [srtf_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tick_time[31:0], ran_slot[35:32], finished[36], finish_time[68:37],
   // turnaround[100:69], waiting[132:101], all_done[133], zero fill
   output logic [srtf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // idle[0]
   output logic [srtf_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import srtf_pkg::*;

   // Control state.
   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic [MAX_TASKS-1:0] pend_ff, pend_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [IDX_W-1:0]     run_slot_ff, run_slot_in;
   logic                 run_vld_ff, run_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Search and result working registers.
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [WORK_W-1:0]     best_rem_ff, best_rem_in;
   logic [WORK_W-1:0]     best_arr_ff, best_arr_in;
   logic [WORK_W-1:0]     best_bur_ff, best_bur_in;
   logic                  rrdy_ff, rrdy_in;
   logic [WORK_W-1:0]     rrem_ff, rrem_in;
   logic [WORK_W-1:0]     rarr_ff, rarr_in;
   logic [WORK_W-1:0]     rbur_ff, rbur_in;
   logic [IDX_W-1:0]      pick_idx_ff, pick_idx_in;
   logic [WORK_W-1:0]     pick_arr_ff, pick_arr_in;
   logic [WORK_W-1:0]     pick_bur_ff, pick_bur_in;
   logic                  fin_ff, fin_in;
   logic [TIME_W-1:0]     done_ff, done_in;
   logic [TIME_W-1:0]     turn_ff, turn_in;
   logic [TIME_W-1:0]     wait_ff, wait_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // Table RAM ports.
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic [ENTRY_W-1:0]   ram_rdata;

   // Request fields.
   cmd_type              req_cmd;
   logic [SLOT_W-1:0]    req_slot;
   logic [WORK_W-1:0]    req_arrival;
   logic [WORK_W-1:0]    req_burst;

   // Entry fields coming back from the RAM.
   logic [WORK_W-1:0]    rd_rem, rd_bur, rd_arr;
   logic                 rd_ready;

   // Helpers for the decision step.
   logic                 use_run;
   logic [WORK_W-1:0]    pick_rem;
   logic [WORK_W-1:0]    new_rem;
   logic [TIME_W-1:0]    time_next;

   assign req_cmd     = cmd_type'(req_tuser);
   assign req_slot    = req_tdata[3:0];
   assign req_arrival = req_tdata[19:4];
   assign req_burst   = req_tdata[35:20];

   assign rd_rem = ram_rdata[WORK_W-1:0];
   assign rd_bur = ram_rdata[2*WORK_W-1:WORK_W];
   assign rd_arr = ram_rdata[3*WORK_W-1:2*WORK_W];

   // An entry is ready when it has work left and has arrived.
   assign rd_ready = cmp_vld_ff && pend_ff[cmp_idx_ff] &&
                     ({{(TIME_W-WORK_W){1'b0}}, rd_arr} <= time_ff);

   assign time_next = (time_ff == TIME_MAX) ? time_ff : time_ff + 1'b1;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Task table: arrival, burst and remaining work per slot.
   srtf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   // Running task wins over the best candidate unless that one is strictly shorter.
   assign use_run  = found_ff && rrdy_ff && (rrem_ff <= best_rem_ff);
   assign pick_rem = use_run ? rrem_ff : best_rem_ff;
   assign new_rem  = pick_rem - 1'b1;

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      pend_in      = pend_ff;
      time_in      = time_ff;
      run_slot_in  = run_slot_ff;
      run_vld_in   = run_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_rem_in  = best_rem_ff;
      best_arr_in  = best_arr_ff;
      best_bur_in  = best_bur_ff;
      rrdy_in      = rrdy_ff;
      rrem_in      = rrem_ff;
      rarr_in      = rarr_ff;
      rbur_in      = rbur_ff;
      pick_idx_in  = pick_idx_ff;
      pick_arr_in  = pick_arr_ff;
      pick_bur_in  = pick_bur_ff;
      fin_in       = fin_ff;
      done_in      = done_ff;
      turn_in      = turn_ff;
      wait_in      = wait_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;

      // Fold the entry returned by the RAM into the running search.
      if (rd_ready) begin
         if (!found_ff || (rd_rem < best_rem_ff)) begin
            found_in    = 1'b1;
            best_idx_in = cmp_idx_ff;
            best_rem_in = rd_rem;
            best_arr_in = rd_arr;
            best_bur_in = rd_bur;
         end
         if (run_vld_ff && (cmp_idx_ff == run_slot_ff)) begin
            rrdy_in = 1'b1;
            rrem_in = rd_rem;
            rarr_in = rd_arr;
            rbur_in = rd_bur;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_cmd)
                  CMD_LOAD: begin
                     if (32'(req_slot) < MAX_TASKS) begin
                        ram_we    = 1'b1;
                        ram_waddr = IDX_W'(req_slot);
                        ram_wdata = {req_arrival, req_burst, req_burst};
                        pend_in[IDX_W'(req_slot)] = (req_burst != '0);
                        if (run_vld_ff && (run_slot_ff == IDX_W'(req_slot))) begin
                           run_vld_in = 1'b0;
                        end
                     end
                  end
                  CMD_TICK: begin
                     found_in  = 1'b0;
                     rrdy_in   = 1'b0;
                     rd_idx_in = '0;
                     state_in  = ST_SCAN;
                  end
                  CMD_CLEAR: begin
                     pend_in     = '0;
                     time_in     = '0;
                     run_slot_in = '0;
                     run_vld_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // One read per cycle; the data is compared in the following cycle.
            cmp_vld_in = 1'b1;
            if (rd_idx_ff == IDX_W'(MAX_TASKS - 1)) begin
               state_in = ST_LAST;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            pick_idx_in = use_run ? run_slot_ff : best_idx_ff;
            pick_arr_in = use_run ? rarr_ff : best_arr_ff;
            pick_bur_in = use_run ? rbur_ff : best_bur_ff;
            fin_in      = found_ff && (new_rem == '0);
            done_in     = (found_ff && (new_rem == '0)) ? time_next : '0;
            if (found_ff) begin
               ram_we      = 1'b1;
               ram_waddr   = pick_idx_in;
               ram_wdata   = {pick_arr_in, pick_bur_in, new_rem};
               run_slot_in = pick_idx_in;
               run_vld_in  = (new_rem != '0);
               if (new_rem == '0) begin
                  pend_in[pick_idx_in] = 1'b0;
               end
            end
            state_in = ST_TURN;
         end
         ST_TURN: begin
            turn_in  = fin_ff ? done_ff - {{(TIME_W-WORK_W){1'b0}}, pick_arr_ff} : '0;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            wait_in = (fin_ff && (turn_ff >= {{(TIME_W-WORK_W){1'b0}}, pick_bur_ff})) ?
                      turn_ff - {{(TIME_W-WORK_W){1'b0}}, pick_bur_ff} : '0;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[31:0]    = time_ff;
               rsp_data_in[35:32]   = found_ff ? SLOT_W'(pick_idx_ff) : '0;
               rsp_data_in[36]      = fin_ff;
               rsp_data_in[68:37]   = done_ff;
               rsp_data_in[100:69]  = turn_ff;
               rsp_data_in[132:101] = wait_ff;
               rsp_data_in[133]     = ~|pend_ff;
               rsp_user_in          = !found_ff;
               time_in              = time_next;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         pend_ff      <= '0;
         time_ff      <= '0;
         run_slot_ff  <= '0;
         run_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         pend_ff      <= pend_in;
         time_ff      <= time_in;
         run_slot_ff  <= run_slot_in;
         run_vld_ff   <= run_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmp_idx_ff  <= rd_idx_ff;
      found_ff    <= found_in;
      best_idx_ff <= best_idx_in;
      best_rem_ff <= best_rem_in;
      best_arr_ff <= best_arr_in;
      best_bur_ff <= best_bur_in;
      rrdy_ff     <= rrdy_in;
      rrem_ff     <= rrem_in;
      rarr_ff     <= rarr_in;
      rbur_ff     <= rbur_in;
      pick_idx_ff <= pick_idx_in;
      pick_arr_ff <= pick_arr_in;
      pick_bur_ff <= pick_bur_in;
      fin_ff      <= fin_in;
      done_ff     <= done_in;
      turn_ff     <= turn_in;
      wait_ff     <= wait_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

// File: src/srtf_chk.sv
// Port-level checker for the scheduler and its bind to the top level.
`include "srtf_tick_scheduler_top_assert.svh"

module srtf_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [srtf_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [srtf_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [srtf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [srtf_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import srtf_pkg::*;

   logic load_or_clear;

   // Beats that never produce a result.
   assign load_or_clear = req_tvalid && req_tready &&
                          ((req_tuser == CMD_LOAD) || (req_tuser == CMD_CLEAR));

   // A stalled result beat keeps its contents.
   `SRTF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result beat changed while stalled")

   // Reset leaves no result pending.
   `SRTF_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_tvalid, "result pending after reset")

   // Load and clear beats never create a result.
   `SRTF_ASSERT_NEXT(a_no_spurious, load_or_clear && !rsp_tvalid, !rsp_tvalid, "result after a load or clear beat")

   // An idle tick reports no slot, no completion and no timing.
   `SRTF_ASSERT_IMPL(a_idle_clean, rsp_tvalid && rsp_tuser[0], (rsp_tdata[35:32] == 4'd0) && !rsp_tdata[36] && (rsp_tdata[68:37] == 32'd0) && (rsp_tdata[100:69] == 32'd0), "idle tick carries task data")

   // Completion is the tick time plus one, saturating.
   `SRTF_ASSERT_IMPL(a_done_time, rsp_tvalid && rsp_tdata[36], rsp_tdata[68:37] == ((rsp_tdata[31:0] == TIME_MAX) ? TIME_MAX : rsp_tdata[31:0] + 32'd1), "completion time mismatch")

endmodule

bind srtf_tick_scheduler_top srtf_chk u_srtf_chk (.*);
